### sv/assert_macros.svh
// assertion macros used by the rtl file interval_timer_statistics_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge, off while rst_n is low
`define ITSTAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising clk edge, off while rst_n is low
`define ITSTAT_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

### sv/itstat_pkg.sv
// package for the interval timer statistics unit: item types, command codes, defaults
package itstat_pkg;

  localparam int TimeBitsDef  = 48;
  localparam int CountBitsDef = 32;

  localparam int OpW    = 3;
  localparam int StampW = 48;
  localparam int CountW = 32;

  localparam logic [OpW-1:0] OP_START    = 3'd0;
  localparam logic [OpW-1:0] OP_PAUSE    = 3'd1;
  localparam logic [OpW-1:0] OP_CONTINUE = 3'd2;
  localparam logic [OpW-1:0] OP_STOP     = 3'd3;
  localparam logic [OpW-1:0] OP_RESET    = 3'd4;
  localparam logic [OpW-1:0] OP_ADOPT    = 3'd5;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [StampW-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic              error;
    logic              running;
    logic              halted;
    logic [CountW-1:0] interval_count;
    logic [StampW-1:0] last_elapsed;
    logic [StampW-1:0] shortest;
    logic [StampW-1:0] longest;
    logic [StampW-1:0] accumulated;
    logic [StampW-1:0] mean;
  } out_item_t;

endpackage

### sv/interval_timer_statistics_unit.sv
// profiling stopwatch with min, max, total and mean of the elapsed intervals
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   itstat_pkg::in_item_t
//   out      output     out_valid/out_stall itstat_pkg::out_item_t
//
// an item runs S_ELAP, S_OUT; a fold inserts S_DIV, a nonzero one also S_SUM, S_MIN, S_MAX
// the mean comes from a restoring divider, one quotient bit per cycle on the shared adder
// every other step (elapsed, total, min, max) is one pass through that same adder
// in_stall is high from acceptance until the result enters the output register
// a stalled result sits in the output register while the next item is accepted
// rst_n is synchronous and clears the timer state and the output valid

`include "assert_macros.svh"

module interval_timer_statistics_unit #(
  parameter int TIME_BITS  = itstat_pkg::TimeBitsDef,
  parameter int COUNT_BITS = itstat_pkg::CountBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  itstat_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output itstat_pkg::out_item_t out_data
);

  localparam int DW = (TIME_BITS > COUNT_BITS + 1) ? TIME_BITS : COUNT_BITS + 1;
  localparam int SW = (TIME_BITS > 1) ? $clog2(TIME_BITS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELAP,
    S_SUM,
    S_MIN,
    S_MAX,
    S_DIV,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  logic [TIME_BITS-1:0]  begin_r, begin_nxt;
  logic [TIME_BITS-1:0]  end_r, end_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [TIME_BITS-1:0]  min_r, min_nxt;
  logic [TIME_BITS-1:0]  max_r, max_nxt;
  logic [TIME_BITS-1:0]  sum_r, sum_nxt;
  logic [TIME_BITS-1:0]  mean_r, mean_nxt;
  logic                  start_r, start_nxt;
  logic                  pause_r, pause_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  err_r, err_nxt;
  logic                  fold_r, fold_nxt;
  logic [TIME_BITS-1:0]  elap_r, elap_nxt;
  logic [TIME_BITS-1:0]  quo_r, quo_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [SW-1:0]         step_r, step_nxt;
  itstat_pkg::out_item_t out_r, out_nxt;

  logic [DW-1:0]         alu_a;
  logic [DW-1:0]         alu_b;
  logic                  alu_sub;
  logic [DW:0]           alu_res;
  logic [COUNT_BITS:0]   div_shift;
  logic [TIME_BITS-1:0]  ts;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign ts        = TIME_BITS'(in_data.timestamp);
  assign div_shift = {rem_r, quo_r[TIME_BITS-1]};

  // shared adder / subtractor, top bit is carry out
  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + {{DW{1'b0}}, alu_sub};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_ELAP: begin
        alu_a   = DW'(end_r);
        alu_b   = DW'(begin_r);
        alu_sub = 1'b1;
      end
      S_SUM: begin
        alu_a = DW'(sum_r);
        alu_b = DW'(elap_r);
      end
      S_MIN: begin
        alu_a   = DW'(elap_r);
        alu_b   = DW'(min_r);
        alu_sub = 1'b1;
      end
      S_MAX: begin
        alu_a   = DW'(max_r);
        alu_b   = DW'(elap_r);
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = DW'(div_shift);
        alu_b   = DW'(count_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    begin_nxt     = begin_r;
    end_nxt       = end_r;
    count_nxt     = count_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    sum_nxt       = sum_r;
    mean_nxt      = mean_r;
    start_nxt     = start_r;
    pause_nxt     = pause_r;
    out_valid_nxt = out_valid_r;
    err_nxt       = err_r;
    fold_nxt      = fold_r;
    elap_nxt      = elap_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_nxt       = out_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_nxt   = 1'b0;
          fold_nxt  = 1'b0;
          state_nxt = S_ELAP;
          unique case (in_data.operation)
            itstat_pkg::OP_START: begin
              if (start_r) begin
                err_nxt = 1'b1;
              end else begin
                begin_nxt = ts;
                start_nxt = 1'b1;
                pause_nxt = 1'b0;
              end
            end
            itstat_pkg::OP_PAUSE: begin
              if (!start_r || pause_r) begin
                err_nxt = 1'b1;
              end else begin
                end_nxt   = ts;
                pause_nxt = 1'b1;
                fold_nxt  = 1'b1;
              end
            end
            itstat_pkg::OP_CONTINUE: begin
              if (!start_r || !pause_r) begin
                err_nxt = 1'b1;
              end else begin
                begin_nxt = ts;
                end_nxt   = ts;
                pause_nxt = 1'b0;
              end
            end
            itstat_pkg::OP_STOP: begin
              if (!start_r) begin
                err_nxt = 1'b1;
              end else begin
                end_nxt   = ts;
                start_nxt = 1'b0;
                pause_nxt = 1'b0;
                fold_nxt  = 1'b1;
                if (count_r != '1) begin
                  count_nxt = count_r + 1'b1;
                end
              end
            end
            itstat_pkg::OP_RESET: begin
              begin_nxt = '0;
              end_nxt   = '0;
              count_nxt = '0;
              min_nxt   = '1;
              max_nxt   = '0;
              sum_nxt   = '0;
              mean_nxt  = '0;
              start_nxt = 1'b0;
              pause_nxt = 1'b0;
            end
            itstat_pkg::OP_ADOPT: begin
              begin_nxt = ts;
              start_nxt = 1'b1;
              pause_nxt = 1'b0;
            end
            default: begin
              err_nxt = 1'b1;
            end
          endcase
        end
      end
      S_ELAP: begin
        if (count_r == '0) begin
          elap_nxt = '0;
        end else begin
          elap_nxt = alu_res[TIME_BITS-1:0];
        end
        if (fold_r && count_r != '0 && alu_res[TIME_BITS-1:0] != '0) begin
          state_nxt = S_SUM;
        end else if (fold_r && count_r != '0) begin
          quo_nxt   = sum_r;
          rem_nxt   = '0;
          step_nxt  = SW'(TIME_BITS - 1);
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SUM: begin
        // saturate the total at all ones
        if (alu_res[TIME_BITS]) begin
          sum_nxt = '1;
        end else begin
          sum_nxt = alu_res[TIME_BITS-1:0];
        end
        state_nxt = S_MIN;
      end
      S_MIN: begin
        if (!alu_res[DW]) begin
          min_nxt = elap_r;
        end
        state_nxt = S_MAX;
      end
      S_MAX: begin
        if (!alu_res[DW]) begin
          max_nxt = elap_r;
        end
        quo_nxt   = sum_r;
        rem_nxt   = '0;
        step_nxt  = SW'(TIME_BITS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (alu_res[DW]) begin
          rem_nxt = alu_res[COUNT_BITS-1:0];
        end else begin
          rem_nxt = div_shift[COUNT_BITS-1:0];
        end
        quo_nxt = {quo_r[TIME_BITS-2:0], alu_res[DW]};
        if (step_r == '0) begin
          mean_nxt  = {quo_r[TIME_BITS-2:0], alu_res[DW]};
          state_nxt = S_OUT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.error          = err_r;
          out_nxt.running        = start_r;
          out_nxt.halted         = pause_r;
          out_nxt.interval_count = itstat_pkg::CountW'(count_r);
          out_nxt.last_elapsed   = itstat_pkg::StampW'(elap_r);
          out_nxt.shortest       = (sum_r != '0) ? itstat_pkg::StampW'(min_r) : '0;
          out_nxt.longest        = itstat_pkg::StampW'(max_r);
          out_nxt.accumulated    = itstat_pkg::StampW'(sum_r);
          out_nxt.mean           = itstat_pkg::StampW'(mean_r);
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      begin_r     <= '0;
      end_r       <= '0;
      count_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      sum_r       <= '0;
      mean_r      <= '0;
      start_r     <= 1'b0;
      pause_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      begin_r     <= begin_nxt;
      end_r       <= end_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      sum_r       <= sum_nxt;
      mean_r      <= mean_nxt;
      start_r     <= start_nxt;
      pause_r     <= pause_nxt;
      out_valid_r <= out_valid_nxt;
    end
    err_r  <= err_nxt;
    fold_r <= fold_nxt;
    elap_r <= elap_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    out_r  <= out_nxt;
  end

  // accepted item starts the sequencer
  `ITSTAT_ASSERT(a_accept_busy, (in_valid && !in_stall) |=> (state_r == S_ELAP), "item did not start")
  // paused implies started
  `ITSTAT_ASSERT_IMP(a_pause_started, pause_r, start_r, "paused while not started")
  // between items, with a sample present, the minimum never exceeds the maximum
  `ITSTAT_ASSERT_IMP(a_min_le_max, (state_r == S_IDLE && sum_r != '0), (min_r <= max_r), "min above max")
  // divider remainder stays below the divisor
  `ITSTAT_ASSERT_IMP(a_rem_bound, (state_r == S_DIV), (rem_r < count_r), "remainder out of range")

endmodule
